/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never be true on an active clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: label");

// property must hold on every active clock edge
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");

`endif

/* hdl/wttbp_pkg.sv */
// ----------------------------------------------------------------------------
// wttbp_pkg
// Shared constants and types of the wavelet tree block pruner.
// ----------------------------------------------------------------------------
package wttbp_pkg;

  localparam int unsigned MAX_POINTS  = 1048576;
  localparam int unsigned COEFF_WIDTH = 32;

  localparam int unsigned W     = 21;
  localparam int unsigned CW    = 32;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTRW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNTW  = $clog2(QDEPTH + 1);

  localparam logic [CW-1:0] COEFF_MASK =
    (COEFF_WIDTH >= CW) ? {CW{1'b1}} : CW'((64'd1 << COEFF_WIDTH) - 64'd1);

  localparam logic [63:0] SKIP_RAW = 64'(2 * 64'(MAX_POINTS) - 64'd2);
  localparam logic [W:0]  SKIP_LIMIT =
    (SKIP_RAW < 64'((1 << W) - 1)) ? (W+1)'(SKIP_RAW) : (W+1)'((1 << W) - 1);

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegMaxLen    = 2'd1;
  localparam logic [1:0] RegDataPts   = 2'd2;

  typedef struct packed {
    logic [CW-1:0] threshold;
    logic [W-1:0]  len_limit;
    logic [W-1:0]  data_points;
  } cfg_t;

  typedef struct packed {
    logic [W-1:0] node_index;
    logic [W-1:0] block_size;
    logic         last_block;
    logic         overrun_error;
  } res_t;

endpackage

/* hdl/wttbp_front.sv */
// ----------------------------------------------------------------------------
// wttbp_front
// Accepts tree nodes, tracks pass state and classifies each node as block.
// ----------------------------------------------------------------------------
module wttbp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wttbp_pkg::cfg_t       cfg_i,
  input  logic                  accept_i,
  input  logic                  first_node_i,
  input  logic [31:0]           coeff_magnitude_i,
  input  logic                  is_leaf_i,
  input  logic [20:0]           node_size_i,
  output logic                  res_push_o,
  output wttbp_pkg::res_t       res_o
);
  import wttbp_pkg::*;

  logic [W-1:0] position_q, position_d;
  logic [W-1:0] skip_left_q, skip_left_d;
  logic [W-1:0] covered_q, covered_d;
  logic         pass_done_q, pass_done_d;

  logic [W-1:0] pos_e, skip_e, cov_e;
  logic         done_e;
  logic         hit;
  logic [W:0]   sum;
  logic [W:0]   skip_new;

  always_comb begin
    pos_e  = first_node_i ? '0 : position_q;
    skip_e = first_node_i ? '0 : skip_left_q;
    cov_e  = first_node_i ? '0 : covered_q;
    done_e = first_node_i ? 1'b0 : pass_done_q;

    hit = (((coeff_magnitude_i & COEFF_MASK) <= (cfg_i.threshold & COEFF_MASK)) || is_leaf_i)
          && ((cfg_i.len_limit == '0) || (node_size_i <= cfg_i.len_limit));
    sum = {1'b0, cov_e} + {1'b0, node_size_i};

    skip_new = (node_size_i == '0) ? '0 : ({node_size_i, 1'b0} - (W+1)'(2));
    if (skip_new > SKIP_LIMIT) skip_new = SKIP_LIMIT;

    position_d  = position_q;
    skip_left_d = skip_left_q;
    covered_d   = covered_q;
    pass_done_d = pass_done_q;
    res_push_o  = 1'b0;

    res_o.node_index    = pos_e;
    res_o.block_size    = node_size_i;
    res_o.last_block    = (sum == {1'b0, cfg_i.data_points});
    res_o.overrun_error = (sum > {1'b0, cfg_i.data_points});

    if (accept_i) begin
      position_d  = pos_e;
      skip_left_d = skip_e;
      covered_d   = cov_e;
      pass_done_d = done_e;
      if (!done_e) begin
        position_d = pos_e + W'(1);
        if (skip_e != '0) begin
          skip_left_d = skip_e - W'(1);
        end else if (hit) begin
          res_push_o = 1'b1;
          covered_d  = sum[W] ? {W{1'b1}} : sum[W-1:0];
          if (res_o.last_block || res_o.overrun_error) begin
            pass_done_d = 1'b1;
          end else begin
            skip_left_d = skip_new[W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q  <= '0;
      skip_left_q <= '0;
      covered_q   <= '0;
      pass_done_q <= 1'b1;
    end else begin
      position_q  <= position_d;
      skip_left_q <= skip_left_d;
      covered_q   <= covered_d;
      pass_done_q <= pass_done_d;
    end
  end

endmodule

/* hdl/wttbp_queue.sv */
// ----------------------------------------------------------------------------
// wttbp_queue
// Short result queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module wttbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wttbp_pkg::res_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output wttbp_pkg::res_t rdata_o
);
  import wttbp_pkg::*;

  res_t             mem_q [QDEPTH];
  logic [QPTRW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNTW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCNTW'(QDEPTH));
  assign avail_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTRW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTRW'(1);
    end
    if (do_push && !do_pop) count_d = count_q + QCNTW'(1);
    if (!do_push && do_pop) count_d = count_q - QCNTW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

/* hdl/wttbp_back.sv */
// ----------------------------------------------------------------------------
// wttbp_back
// Output stage: holds the oldest result beat for the consumer.
// ----------------------------------------------------------------------------
module wttbp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  wttbp_pkg::res_t rdata_i,
  output logic            take_o,
  input  logic            pop,
  output logic            empty,
  output wttbp_pkg::res_t res_o
);
  import wttbp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign empty  = !valid_q;
  assign res_o  = res_q;
  assign take_o = avail_i && (!valid_q || pop);

  always_comb begin
    valid_d = valid_q;
    if (take_o)          valid_d = 1'b1;
    else if (pop)        valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) res_q <= rdata_i;
  end

endmodule

/* hdl/wavelet_tree_threshold_block_pruner.sv */
// ----------------------------------------------------------------------------
// wavelet_tree_threshold_block_pruner
// Selects blocks from a depth-first stream of Haar max-coefficient nodes.
// ----------------------------------------------------------------------------
// Takes one tree node per cycle: the node decision and the position, skip
// and coverage update are done combinationally in the front classifier,
// so push may stay high every cycle while the result side keeps up. A
// chosen block reaches the result ports after its node is accepted
// through a two-entry queue and then an output register; full is high
// while both queue entries hold beats behind an occupied output register,
// so up to three blocks can wait on a stalled consumer.
// ----------------------------------------------------------------------------
module wavelet_tree_threshold_block_pruner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        first_node_i,
  input  logic [31:0] coeff_magnitude_i,
  input  logic        is_leaf_i,
  input  logic [20:0] node_size_i,
  output logic        empty,
  input  logic        pop,
  output logic [20:0] node_index_o,
  output logic [20:0] block_size_o,
  output logic        last_block_o,
  output logic        overrun_error_o
);
  import wttbp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cfg_we;
  logic accept;
  logic res_push, q_avail, q_take;
  res_t res_front, res_head, res_out;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (paddr[3:2])
        RegThreshold: cfg_d.threshold     = pwdata;
        RegMaxLen:    cfg_d.len_limit     = pwdata[W-1:0];
        RegDataPts:   cfg_d.data_points   = pwdata[W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegThreshold: prdata = cfg_q.threshold;
      RegMaxLen:    prdata = {11'd0, cfg_q.len_limit};
      RegDataPts:   prdata = {11'd0, cfg_q.data_points};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= '0;
      cfg_q.len_limit     <= '0;
      cfg_q.data_points   <= W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = push && !full;

  wttbp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .accept_i          (accept),
    .first_node_i      (first_node_i),
    .coeff_magnitude_i (coeff_magnitude_i),
    .is_leaf_i         (is_leaf_i),
    .node_size_i       (node_size_i),
    .res_push_o        (res_push),
    .res_o             (res_front)
  );

  wttbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_front),
    .full_o  (full),
    .pop_i   (q_take),
    .avail_o (q_avail),
    .rdata_o (res_head)
  );

  wttbp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (q_avail),
    .rdata_i (res_head),
    .take_o  (q_take),
    .pop     (pop),
    .empty   (empty),
    .res_o   (res_out)
  );

  assign node_index_o    = res_out.node_index;
  assign block_size_o    = res_out.block_size;
  assign last_block_o    = res_out.last_block;
  assign overrun_error_o = res_out.overrun_error;

endmodule

/* hdl/wttbp_checker.sv */
// ----------------------------------------------------------------------------
// wttbp_checker
// Port-level checks of the block pruner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wttbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [20:0] node_index_o,
  input logic        last_block_o,
  input logic        overrun_error_o
);

  // a beat never flags both pass end kinds
  `ASSERT_NEVER(a_flags_excl, clk_i, rst_ni, !empty && last_block_o && overrun_error_o)

  // a full queue implies the output stage already holds a beat
  `ASSERT_NEVER(a_full_has_out, clk_i, rst_ni, full && empty)

  `ASSERT_PROP(a_hold, clk_i, rst_ni,
               (!empty && !pop) |=> (!empty && $stable(node_index_o)))

  `ASSERT_PROP(a_ready, clk_i, rst_ni, pready && !(push && full && $past(full) && empty))

endmodule

bind wavelet_tree_threshold_block_pruner wttbp_checker u_wttbp_checker (.*);
